// ===== hw/rtl/ab2x_pkg.sv =====
// ----------------------------------------------------------------------------
// ab2x_pkg
// Shared types, register codes and sizes of the 2x bicubic upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package ab2x_pkg;

   localparam int PIX_W           = 8;
   localparam int COORD_W         = 11;
   localparam int CFG_W           = 11;
   localparam int CSR_IDX_W       = 2;
   localparam int DEF_MAX_WIDTH   = 1024;
   localparam int DEF_MAX_HEIGHT  = 1024;
   localparam int LINE_BUFFERS    = 4;
   localparam int LB_IDX_W        = 2;
   localparam int MIN_SIZE        = 4;

   localparam logic [CFG_W-1:0]     CFG_SIZE_RESET  = CFG_W'(1024);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = CSR_IDX_W'(1);

   // four filter taps, entry 0 is the leftmost / topmost
   typedef logic [3:0][PIX_W-1:0] tap_set_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ADDR,
      ST_DATA,
      ST_HPASS,
      ST_VPASS,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ab2x_cubic.sv =====
// ----------------------------------------------------------------------------
// ab2x_cubic
// Shared 4-tap cubic filter (-1,5,5,-1)/8 with clamp and overshoot guard.
// ----------------------------------------------------------------------------
`default_nettype none

module ab2x_cubic
   import ab2x_pkg::*;
(
   input  wire tap_set_type  taps,
   output logic [PIX_W-1:0]  result
);

   logic signed [12:0] sum;
   logic [PIX_W-1:0]   clamped;
   logic [PIX_W:0]     pair;

   always_comb begin
      sum = 13'sd5 * ($signed({5'd0, taps[1]}) + $signed({5'd0, taps[2]}))
            - $signed({5'd0, taps[0]}) - $signed({5'd0, taps[3]});
      if (sum < 0) begin
         clamped = '0;
      end else if (sum[12:3] > 10'd255) begin
         clamped = 8'd255;
      end else begin
         clamped = sum[10:3];
      end
      pair = {1'b0, taps[1]} + {1'b0, taps[2]};
      // both neighbours on one side: fall back to their mean
      if ((taps[1] > clamped && taps[2] > clamped) ||
          (taps[1] < clamped && taps[2] < clamped)) begin
         result = pair[PIX_W:1];
      end else begin
         result = clamped;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ab2x_line_store.sv =====
// ----------------------------------------------------------------------------
// ab2x_line_store
// Four source lines, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ab2x_line_store
   import ab2x_pkg::*;
#(
   parameter int DEPTH  = LINE_BUFFERS * DEF_MAX_WIDTH,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [PIX_W-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [PIX_W-1:0]  rd_data
);

   logic [PIX_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/adaptive_bicubic_2x_upscaler.sv =====
// ----------------------------------------------------------------------------
// adaptive_bicubic_2x_upscaler
// 2x image upscaler: cubic interpolation with an overshoot guard.
// ----------------------------------------------------------------------------
// Use: source pixels enter in raster order on req_ (valid/stall). Each word
// at source (r,c) yields the 2x2 output block of (r-2,c-2); the last column
// and last row also flush the trailing blocks, up to 36 words for the last
// pixel of a frame. Results leave on rsp_ (valid/stall) with their output
// coordinates; last_of_run marks the final word of one source pixel and
// frame_done the final word of the frame.
// Rate: one source pixel at a time. After the accept each output word goes
// from SETUP to OUT; at a border it goes straight there, else it first reads
// each tap through ADDR and DATA on the single read port of the line store,
// forms each row value in HPASS and the word in VPASS, with the one shared
// cubic unit serving both passes.
// After accepting a pixel that yields words, req_stall is high until the last word of that pixel is taken.
// A stall on rsp_ holds the word on the port and freezes the sequencer.
// Reset (synchronous) returns the sequencer to idle, clears the position
// counters and sets both size registers to 1024; line contents stay as they
// were. csr_ writes are always ready and belong between frames or in idle.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_bicubic_2x_upscaler
   import ab2x_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // source pixels
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [PIX_W-1:0]      req_pixel,
   // upscaled words
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [COORD_W-1:0]    rsp_out_row,
   output logic      [COORD_W-1:0]    rsp_out_col,
   output logic      [PIX_W-1:0]      rsp_value,
   output logic                       rsp_last_of_run,
   output logic                       rsp_frame_done,
   // register writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_W-1:0]      csr_data
);

   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int RW     = $clog2(MAX_HEIGHT);
   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int HW     = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH  = LINE_BUFFERS * MAX_WIDTH;
   localparam int ADDR_W = $clog2(DEPTH);

   // control
   state_type            st_ff, st_in;
   logic [CFG_W-1:0]     width_ff, width_in, height_ff, height_in;
   logic [CW-1:0]        col_ff, col_in;
   logic [RW-1:0]        row_ff, row_in;

   // run of blocks for the current pixel
   logic [CW-1:0]        bc_ff, bc_in, bc_start_ff, bc_start_in, bc_end_ff, bc_end_in;
   logic [RW-1:0]        br_ff, br_in, br_end_ff, br_end_in;
   logic [1:0]           q_ff, q_in;
   logic                 frame_end_ff, frame_end_in;
   logic [1:0]           i_ff, i_in, j_ff, j_in;
   tap_set_type          tap_ff, tap_in, rowv_ff, rowv_in;
   logic [PIX_W-1:0]     res_ff, res_in;

   // combinational helpers
   logic [WW-1:0]        w_use;
   logic [HW-1:0]        h_use;
   logic [CW-1:0]        c_use;
   logic [RW-1:0]        r_use;
   logic                 c_last, r_last, req_acc, emit;
   logic                 odd_col, odd_row, col_zero, row_zero;
   logic                 last_tap, last_rowv, last_pix;
   logic [CW-1:0]        tap_col;
   logic [LB_IDX_W-1:0]  tap_row;
   logic [ADDR_W-1:0]    wr_addr, rd_addr;
   logic [PIX_W-1:0]     rd_data, cub_out;
   tap_set_type          cub_in;

   // sizes in use, limited to 4..MAX
   always_comb begin
      if (32'(width_ff) < 32'(MIN_SIZE)) begin
         w_use = WW'(MIN_SIZE);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         w_use = WW'(MAX_WIDTH);
      end else begin
         w_use = WW'(width_ff);
      end
      if (32'(height_ff) < 32'(MIN_SIZE)) begin
         h_use = HW'(MIN_SIZE);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         h_use = HW'(MAX_HEIGHT);
      end else begin
         h_use = HW'(height_ff);
      end
   end

   // position in use, pinned to the last index after a size change
   always_comb begin
      c_use   = (WW'(col_ff) < w_use) ? col_ff : CW'(w_use - WW'(1));
      r_use   = (HW'(row_ff) < h_use) ? row_ff : RW'(h_use - HW'(1));
      c_last  = (WW'(c_use) == w_use - WW'(1));
      r_last  = (HW'(r_use) == h_use - HW'(1));
      req_acc = req_valid && !req_stall;
      emit    = (r_use >= RW'(2)) && (c_use >= CW'(2));
   end

   // current output word
   always_comb begin
      odd_col   = q_ff[0];
      odd_row   = q_ff[1];
      col_zero  = odd_col && ((bc_ff == '0) ||
                  ((WW+1)'(bc_ff) + (WW+1)'(3) > (WW+1)'(w_use)));
      row_zero  = odd_row && ((br_ff == '0) ||
                  ((HW+1)'(br_ff) + (HW+1)'(3) > (HW+1)'(h_use)));
      last_tap  = odd_col ? (i_ff == 2'd3) : 1'b1;
      last_rowv = odd_row ? (j_ff == 2'd3) : 1'b1;
      last_pix  = (q_ff == 2'd3) && (bc_ff == bc_end_ff) && (br_ff == br_end_ff);
      tap_col   = odd_col ? CW'(bc_ff + CW'(i_ff) - CW'(1)) : bc_ff;
      tap_row   = odd_row ? LB_IDX_W'(br_ff[LB_IDX_W-1:0] + j_ff - 2'd1)
                          : br_ff[LB_IDX_W-1:0];
      rd_addr   = ADDR_W'(ADDR_W'(tap_row) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(tap_col);
      wr_addr   = ADDR_W'(ADDR_W'(r_use[LB_IDX_W-1:0]) * ADDR_W'(MAX_WIDTH))
                  + ADDR_W'(c_use);
      cub_in    = (st_ff == ST_HPASS) ? tap_ff : rowv_ff;
   end

   ab2x_line_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_lines (
      .clock   (clock),
      .wr_en   (req_acc),
      .wr_addr (wr_addr),
      .wr_data (req_pixel),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // one filter serves both the row pass and the column pass
   ab2x_cubic u_cubic (
      .taps   (cub_in),
      .result (cub_out)
   );

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:  if (req_acc && emit) st_in = ST_SETUP;
         ST_SETUP: st_in = (col_zero || row_zero) ? ST_OUT : ST_ADDR;
         ST_ADDR:  st_in = ST_DATA;
         ST_DATA:  st_in = last_tap ? ST_HPASS : ST_ADDR;
         ST_HPASS: st_in = last_rowv ? ST_VPASS : ST_ADDR;
         ST_VPASS: st_in = ST_OUT;
         ST_OUT:   if (!rsp_stall) st_in = last_pix ? ST_IDLE : ST_SETUP;
         default:  st_in = ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      bc_in        = bc_ff;
      bc_start_in  = bc_start_ff;
      bc_end_in    = bc_end_ff;
      br_in        = br_ff;
      br_end_in    = br_end_ff;
      q_in         = q_ff;
      frame_end_in = frame_end_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      tap_in       = tap_ff;
      rowv_in      = rowv_ff;
      res_in       = res_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_data;
            CSR_IMAGE_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end

      case (st_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (c_last) begin
                  col_in = '0;
                  row_in = r_last ? '0 : RW'(r_use + RW'(1));
               end else begin
                  col_in = CW'(c_use + CW'(1));
                  row_in = r_use;
               end
               bc_in        = CW'(c_use - CW'(2));
               bc_start_in  = CW'(c_use - CW'(2));
               bc_end_in    = c_last ? c_use : CW'(c_use - CW'(2));
               br_in        = RW'(r_use - RW'(2));
               br_end_in    = r_last ? r_use : RW'(r_use - RW'(2));
               q_in         = '0;
               frame_end_in = c_last && r_last;
            end
         end
         ST_SETUP: begin
            i_in   = '0;
            j_in   = '0;
            res_in = '0;
         end
         ST_DATA: begin
            tap_in[i_ff] = rd_data;
            i_in         = i_ff + 2'd1;
         end
         ST_HPASS: begin
            rowv_in[j_ff] = odd_col ? cub_out : tap_ff[0];
            i_in          = '0;
            j_in          = j_ff + 2'd1;
         end
         ST_VPASS: begin
            res_in = odd_row ? cub_out : rowv_ff[0];
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               q_in = q_ff + 2'd1;
               if (q_ff == 2'd3) begin
                  if (bc_ff != bc_end_ff) begin
                     bc_in = CW'(bc_ff + CW'(1));
                  end else begin
                     bc_in = bc_start_ff;
                     br_in = RW'(br_ff + RW'(1));
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      req_stall       = (st_ff != ST_IDLE);
      csr_ready       = 1'b1;
      rsp_valid       = (st_ff == ST_OUT);
      rsp_out_row     = COORD_W'({br_ff, q_ff[1]});
      rsp_out_col     = COORD_W'({bc_ff, q_ff[0]});
      rsp_value       = res_ff;
      rsp_last_of_run = last_pix;
      rsp_frame_done  = last_pix && frame_end_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         width_ff  <= CFG_SIZE_RESET;
         height_ff <= CFG_SIZE_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         st_ff     <= st_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      bc_ff        <= bc_in;
      bc_start_ff  <= bc_start_in;
      bc_end_ff    <= bc_end_in;
      br_ff        <= br_in;
      br_end_ff    <= br_end_in;
      q_ff         <= q_in;
      frame_end_ff <= frame_end_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      tap_ff       <= tap_in;
      rowv_ff      <= rowv_in;
      res_ff       <= res_in;
   end

`ifndef SYNTHESIS
   // no new pixel is taken while a word waits
   a_busy_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("pixel accepted while a result is pending");

   // a pixel never produces a word in the very next cycle
   a_accept_gap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid)
      else $error("result straight after accept");

   // the run ends after its last word
   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_of_run) |=> (!rsp_valid && !req_stall))
      else $error("sequencer kept running after the last word");

   a_frame_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> rsp_last_of_run)
      else $error("frame end not on the last word of a run");
`endif

endmodule

`default_nettype wire
